@@ src/aatsps_pkg.sv @@
// Shared types and constants for the anti-aliased thick segment pixel shader.
// Depends on nothing; every other file of the block refers to it by scoped names.
package aatsps_pkg;

	localparam int SUB_PER_PX = 16;

	// Subsample offsets inside one pixel, in sixteenths.
	localparam logic [3:0] SAMPLE_OFF [3] = '{4'd3, 4'(SUB_PER_PX / 2), 4'(SUB_PER_PX - 3)};

	localparam logic [8:0] ALPHA_FULL = 9'd256;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_START_X       = 3'd0,
		REG_START_Y       = 3'd1,
		REG_END_X         = 3'd2,
		REG_END_Y         = 3'd3,
		REG_THICKNESS     = 3'd4,
		REG_PEN_COLOUR    = 3'd5,
		REG_CANVAS_WIDTH  = 3'd6,
		REG_CANVAS_HEIGHT = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [8:0]  pixel_x;
		logic [8:0]  pixel_y;
		logic [15:0] old_colour;
	} pixel_word_t;

	typedef struct packed {
		logic        write_enable;
		logic [15:0] new_colour;
		logic [3:0]  coverage;
	} shade_word_t;

	// Blend weight out of 256 for a subsample hit count.
	function automatic logic [8:0] alpha_of(input logic [3:0] hits);
		logic [8:0] a;
		case (hits)
			4'd0: a = 9'd0;
			4'd1: a = 9'd28;
			4'd2: a = 9'd57;
			4'd3: a = 9'd85;
			4'd4: a = 9'd114;
			4'd5: a = 9'd142;
			4'd6: a = 9'd171;
			4'd7: a = 9'd199;
			4'd8: a = 9'd228;
			4'd9: a = 9'd256;
			default: a = 9'd0;
		endcase
		return a;
	endfunction

endpackage

@@ src/aatsps_pixel_if.sv @@
// Input channel carrying one pixel word (coordinate and current colour).
// Depends on aatsps_pkg for the payload type.
interface aatsps_pixel_if;
	logic                      valid;
	logic                      ready;
	aatsps_pkg::pixel_word_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/aatsps_shade_if.sv @@
// Output channel carrying one shaded word (write flag, colour, coverage).
// Depends on aatsps_pkg for the payload type.
interface aatsps_shade_if;
	logic                      valid;
	logic                      ready;
	aatsps_pkg::shade_word_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/aa_thick_segment_pixel_shader.sv @@
// Throughput one word per clock, with each stage advancing whenever the stage after it is
// empty or moving. After reset, and after every configuration write, a setup sequencer
// (the differences, the squares, the sum, 16 square root steps, then the scale) derives
// the segment constants; the input is not ready during it.
// Reset is asynchronous and active low; it restores the register defaults and empties the pipe.
module aa_thick_segment_pixel_shader #(
	parameter int CANVAS_MAX = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	aatsps_pixel_if.sink         pix_in,
	aatsps_shade_if.source       shade_out
);

	localparam logic [9:0] CANVAS_LIM = 10'(CANVAS_MAX);

	// Configuration registers.
	logic signed [13:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic [9:0]         thickness_q;
	logic [15:0]        pen_colour_q;
	logic [9:0]         canvas_width_q, canvas_height_q;

	// Segment constants derived by the setup sequencer.
	logic signed [14:0] dx_q, dy_q;
	logic signed [29:0] sqx_q, sqy_q;
	logic [29:0]        len2_q;
	logic               len_zero_q;
	logic [17:0]        rr_q;
	logic               r_pos_q;
	logic [24:0]        rlen_q;
	logic [31:0]        rad_q, rem_q, root_q;
	logic [3:0]         iter_q;

	typedef enum logic [2:0] {
		ST_DIFF, ST_SQUARE, ST_SUM, ST_ROOT, ST_SCALE, ST_READY
	} setup_state_t;
	setup_state_t state_q;

	logic [8:0] radius;
	assign radius = thickness_q[9:1];

	// One step of the bitwise square root: two radicand bits enter per cycle.
	logic [31:0] root_sh, rem_sh, root_nx, rem_nx;
	always_comb begin
		root_sh = {root_q[30:0], 1'b0};
		rem_sh  = {rem_q[29:0], rad_q[31:30]};
		if (root_sh < rem_sh) begin
			rem_nx  = rem_sh - (root_sh | 32'd1);
			root_nx = root_sh + 32'd2;
		end else begin
			rem_nx  = rem_sh;
			root_nx = root_sh;
		end
	end

	// Configuration writes and the setup sequencer. Any write restarts the sequence, so the
	// constants always match the registers before the next pixel is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q       <= '0;
			start_y_q       <= '0;
			end_x_q         <= '0;
			end_y_q         <= '0;
			thickness_q     <= '0;
			pen_colour_q    <= '0;
			canvas_width_q  <= 10'd512;
			canvas_height_q <= 10'd512;
			state_q         <= ST_DIFF;
			dx_q            <= '0;
			dy_q            <= '0;
			sqx_q           <= '0;
			sqy_q           <= '0;
			len2_q          <= '0;
			len_zero_q      <= 1'b1;
			rr_q            <= '0;
			r_pos_q         <= 1'b0;
			rlen_q          <= '0;
			rad_q           <= '0;
			rem_q           <= '0;
			root_q          <= '0;
			iter_q          <= '0;
		end else if (cfg_we) begin
			unique case (aatsps_pkg::reg_index_t'(cfg_index))
				aatsps_pkg::REG_START_X:       start_x_q       <= cfg_data[13:0];
				aatsps_pkg::REG_START_Y:       start_y_q       <= cfg_data[13:0];
				aatsps_pkg::REG_END_X:         end_x_q         <= cfg_data[13:0];
				aatsps_pkg::REG_END_Y:         end_y_q         <= cfg_data[13:0];
				aatsps_pkg::REG_THICKNESS:     thickness_q     <= cfg_data[9:0];
				aatsps_pkg::REG_PEN_COLOUR:    pen_colour_q    <= cfg_data;
				aatsps_pkg::REG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data[9:0];
				aatsps_pkg::REG_CANVAS_HEIGHT: canvas_height_q <= cfg_data[9:0];
				default: ;
			endcase
			state_q <= ST_DIFF;
		end else begin
			unique case (state_q)
				ST_DIFF: begin
					dx_q    <= 15'(end_x_q) - 15'(start_x_q);
					dy_q    <= 15'(end_y_q) - 15'(start_y_q);
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					sqx_q   <= dx_q * dx_q;
					sqy_q   <= dy_q * dy_q;
					rr_q    <= radius * radius;
					r_pos_q <= (radius != 9'd0);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					len2_q     <= 30'(sqx_q + sqy_q);
					len_zero_q <= (sqx_q == 30'sd0) && (sqy_q == 30'sd0);
					rad_q      <= {2'b00, 30'(sqx_q + sqy_q)};
					rem_q      <= '0;
					root_q     <= '0;
					iter_q     <= '0;
					state_q    <= ST_ROOT;
				end
				ST_ROOT: begin
					rad_q  <= {rad_q[29:0], 2'b00};
					rem_q  <= rem_nx;
					root_q <= root_nx;
					iter_q <= iter_q + 4'd1;
					if (iter_q == 4'd15) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					rlen_q  <= radius * root_q[16:1];
					state_q <= ST_READY;
				end
				ST_READY: begin
					state_q <= ST_READY;
				end
			endcase
		end
	end

	// Stage enables: a stage loads when it is empty or its contents move on.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	assign en6 = !v_s6 || shade_out.ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign pix_in.ready = en1 && (state_q == ST_READY);

	logic accept;
	assign accept = pix_in.valid && pix_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= accept;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: subsample offsets from the start and end points, and the canvas test. The x and y parts are
	// separable, so three columns and three rows cover all nine subsamples.
	logic signed [15:0] ux_s1 [3];
	logic signed [15:0] uy_s1 [3];
	logic signed [15:0] qx_s1 [3];
	logic signed [15:0] qy_s1 [3];
	logic               inside_s1;
	logic [15:0]        old_s1;

	logic [9:0] wlim, hlim;
	assign wlim = (canvas_width_q < CANVAS_LIM) ? canvas_width_q : CANVAS_LIM;
	assign hlim = (canvas_height_q < CANVAS_LIM) ? canvas_height_q : CANVAS_LIM;

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 3; i++) begin
				ux_s1[i] <= $signed({3'b000, pix_in.data.pixel_x, aatsps_pkg::SAMPLE_OFF[i]})
					- 16'(start_x_q);
				uy_s1[i] <= $signed({3'b000, pix_in.data.pixel_y, aatsps_pkg::SAMPLE_OFF[i]})
					- 16'(start_y_q);
				qx_s1[i] <= $signed({3'b000, pix_in.data.pixel_x, aatsps_pkg::SAMPLE_OFF[i]})
					- 16'(end_x_q);
				qy_s1[i] <= $signed({3'b000, pix_in.data.pixel_y, aatsps_pkg::SAMPLE_OFF[i]})
					- 16'(end_y_q);
			end
			inside_s1 <= ({1'b0, pix_in.data.pixel_x} < wlim)
				&& ({1'b0, pix_in.data.pixel_y} < hlim);
			old_s1 <= pix_in.data.old_colour;
		end
	end

	// Stage 2: the separable products for projection, cross product and both distances.
	logic signed [31:0] pdx_s2 [3];
	logic signed [31:0] pdy_s2 [3];
	logic signed [31:0] cdy_s2 [3];
	logic signed [31:0] cdx_s2 [3];
	logic signed [31:0] sxx_s2 [3];
	logic signed [31:0] syy_s2 [3];
	logic signed [31:0] exx_s2 [3];
	logic signed [31:0] eyy_s2 [3];
	logic               inside_s2;
	logic [15:0]        old_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < 3; i++) begin
				pdx_s2[i] <= ux_s1[i] * dx_q;
				pdy_s2[i] <= uy_s1[i] * dy_q;
				cdy_s2[i] <= ux_s1[i] * dy_q;
				cdx_s2[i] <= uy_s1[i] * dx_q;
				sxx_s2[i] <= ux_s1[i] * ux_s1[i];
				syy_s2[i] <= uy_s1[i] * uy_s1[i];
				exx_s2[i] <= qx_s1[i] * qx_s1[i];
				eyy_s2[i] <= qy_s1[i] * qy_s1[i];
			end
			inside_s2 <= inside_s1;
			old_s2    <= old_s1;
		end
	end

	// Stage 3: per-subsample sums. Subsample k sits in row j and column i, k = 3j + i.
	logic signed [31:0] dot_s3 [9];
	logic signed [31:0] cr_s3 [9];
	logic signed [31:0] d2s_s3 [9];
	logic signed [31:0] d2e_s3 [9];
	logic               inside_s3;
	logic [15:0]        old_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					dot_s3[3 * j + i] <= pdx_s2[i] + pdy_s2[j];
					cr_s3[3 * j + i]  <= cdy_s2[i] - cdx_s2[j];
					d2s_s3[3 * j + i] <= sxx_s2[i] + syy_s2[j];
					d2e_s3[3 * j + i] <= exx_s2[i] + eyy_s2[j];
				end
			end
			inside_s3 <= inside_s2;
			old_s3    <= old_s2;
		end
	end

	// Stage 4: pick the test that applies to each subsample: start cap, end cap or body.
	logic signed [31:0] len2_w, rr_w, rlen_w;
	assign len2_w = $signed({2'b00, len2_q});
	assign rr_w   = $signed({14'd0, rr_q});
	assign rlen_w = $signed({7'd0, rlen_q});

	logic [8:0]  hit_s4;
	logic        inside_s4;
	logic [15:0] old_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int k = 0; k < 9; k++) begin
				if (len_zero_q || dot_s3[k] <= 32'sd0) begin
					hit_s4[k] <= r_pos_q && (d2s_s3[k] <= rr_w);
				end else if (dot_s3[k] >= len2_w) begin
					hit_s4[k] <= r_pos_q && (d2e_s3[k] <= rr_w);
				end else begin
					hit_s4[k] <= r_pos_q && (cr_s3[k] <= rlen_w) && (cr_s3[k] >= -rlen_w);
				end
			end
			inside_s4 <= inside_s3;
			old_s4    <= old_s3;
		end
	end

	// Stage 5: coverage count and its blend weight.
	logic [3:0] hit_count;
	always_comb begin
		hit_count = '0;
		for (int k = 0; k < 9; k++) begin
			hit_count = hit_count + {3'b000, hit_s4[k]};
		end
	end

	logic [3:0]  cov_s5;
	logic [8:0]  alpha_s5;
	logic        we_s5;
	logic [15:0] old_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			cov_s5   <= hit_count;
			alpha_s5 <= aatsps_pkg::alpha_of(hit_count);
			we_s5    <= (hit_count != 4'd0) && inside_s4;
			old_s5   <= old_s4;
		end
	end

	// Stage 6: RGB565 blend per channel, then the output word.
	logic [8:0]  inv_alpha;
	logic [14:0] mix_r, mix_g, mix_b;
	logic [15:0] blended, colour;

	assign inv_alpha = aatsps_pkg::ALPHA_FULL - alpha_s5;
	assign mix_r = 15'(pen_colour_q[15:11]) * 15'(alpha_s5)
		+ 15'(old_s5[15:11]) * 15'(inv_alpha);
	assign mix_g = 15'(pen_colour_q[10:5]) * 15'(alpha_s5)
		+ 15'(old_s5[10:5]) * 15'(inv_alpha);
	assign mix_b = 15'(pen_colour_q[4:0]) * 15'(alpha_s5)
		+ 15'(old_s5[4:0]) * 15'(inv_alpha);
	assign blended = {mix_r[12:8], mix_g[13:8], mix_b[12:8]};

	always_comb begin
		if (!we_s5) begin
			colour = old_s5;
		end else if (alpha_s5 == aatsps_pkg::ALPHA_FULL) begin
			colour = pen_colour_q;
		end else begin
			colour = blended;
		end
	end

	aatsps_pkg::shade_word_t out_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			out_s6.write_enable <= we_s5;
			out_s6.new_colour   <= colour;
			out_s6.coverage     <= cov_s5;
		end
	end

	assign shade_out.valid = v_s6;
	assign shade_out.data  = out_s6;

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the anti-aliased thick segment pixel shader: random and directed pixel
// words checked against an in-bench coverage and blend predictor.
// Depends on aatsps_pkg and the two channel interfaces of the block.
module tb_top;

	typedef struct packed {
		logic        write_enable;
		logic [15:0] new_colour;
		logic [3:0]  coverage;
	} shade_t;

	// Segment settings mirrored by the bench.
	int seg_ax, seg_ay, seg_bx, seg_by;
	int pen_width;
	logic [15:0] stroke_colour;
	int canvas_w, canvas_h;

	// Bitwise integer square root, the same digit-by-digit method as the block.
	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned rem, root;
		logic [31:0] x;
		x = v[31:0];
		rem = 0;
		root = 0;
		for (int i = 0; i < 16; i++) begin
			root = root << 1;
			rem = (rem << 2) | x[31:30];
			x = x << 2;
			if (root < rem) begin
				rem = rem - (root | 1);
				root = root + 2;
			end
		end
		return root >> 1;
	endfunction

	function automatic int unsigned weight_of_hits(input int h);
		int unsigned w [10] = '{0, 28, 57, 85, 114, 142, 171, 199, 228, 256};
		return w[h];
	endfunction

	function automatic int unsigned mix(input int unsigned s, d, a);
		return (s * a + d * (256 - a)) >> 8;
	endfunction

	// Predicts the shaded word for one pixel under the current segment settings.
	function automatic shade_t shade_pixel(input aatsps_pkg::pixel_word_t p);
		longint r, dx, dy, len2, rlen, sx, sy, ux, uy, dot, qx, qy, cr;
		longint offs [3] = '{3, 8, 13};
		int hits;
		int unsigned a, rr, gg, bb;
		shade_t s;
		r = pen_width >> 1;
		dx = seg_bx - seg_ax;
		dy = seg_by - seg_ay;
		len2 = dx * dx + dy * dy;
		rlen = r * longint'(isqrt(len2));
		hits = 0;
		if (r > 0) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					sx = longint'(p.pixel_x) * 16 + offs[i];
					sy = longint'(p.pixel_y) * 16 + offs[j];
					ux = sx - seg_ax;
					uy = sy - seg_ay;
					dot = ux * dx + uy * dy;
					if (len2 == 0 || dot <= 0) begin
						if (ux * ux + uy * uy <= r * r) hits++;
					end else if (dot >= len2) begin
						qx = sx - seg_bx;
						qy = sy - seg_by;
						if (qx * qx + qy * qy <= r * r) hits++;
					end else begin
						cr = ux * dy - uy * dx;
						if (cr <= rlen && -cr <= rlen) hits++;
					end
				end
			end
		end
		s.coverage = 4'(hits);
		s.write_enable = hits > 0 && p.pixel_x < (canvas_w < 512 ? canvas_w : 512)
			&& p.pixel_y < (canvas_h < 512 ? canvas_h : 512);
		s.new_colour = p.old_colour;
		if (s.write_enable) begin
			a = weight_of_hits(hits);
			if (a >= 256) begin
				s.new_colour = stroke_colour;
			end else begin
				rr = mix(stroke_colour[15:11], p.old_colour[15:11], a);
				gg = mix(stroke_colour[10:5], p.old_colour[10:5], a);
				bb = mix(stroke_colour[4:0], p.old_colour[4:0], a);
				s.new_colour = {rr[4:0], gg[5:0], bb[4:0]};
			end
		end
		return s;
	endfunction

	// Holds the words expected from the block, in order, and counts mismatches.
	class shade_scoreboard;
		shade_t pending [$];
		int errors;

		function void note_pixel(shade_t s);
			pending.push_back(s);
		endfunction

		function void check_shade(shade_t got);
			shade_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected shaded word %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.write_enable !== want.write_enable)
				$display("%0t: write_enable expected %b actual %b", $time,
					want.write_enable, got.write_enable);
			if (got.new_colour !== want.new_colour)
				$display("%0t: new_colour expected %h actual %h", $time,
					want.new_colour, got.new_colour);
			if (got.coverage !== want.coverage)
				$display("%0t: coverage expected %0d actual %0d", $time,
					want.coverage, got.coverage);
			if (got !== want) errors++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = aatsps_pkg::REG_START_X;
	logic [15:0] cfg_data = '0;

	aatsps_pixel_if pix_in ();
	aatsps_shade_if shade_out ();

	aa_thick_segment_pixel_shader dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix_in(pix_in.sink), .shade_out(shade_out.source)
	);

	always #4 clk = ~clk;

	shade_scoreboard board = new();
	int send_idle_pct = 8;  // chance in a hundred that the sender skips a cycle
	int recv_idle_pct = 66; // same for the receiver
	bit hold_off = 1'b0;    // forces a long receiver stall while set
	longint cycles = 0;

	initial begin
		pix_in.valid = 1'b0;
		pix_in.data = '0;
		shade_out.ready = 1'b0;
	end

	// The run is cut off well past the slowest correct run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Receiver: ready is dropped at random, or held low while a stall is forced.
	// Every accepted shaded word is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && shade_out.valid && shade_out.ready)
			board.check_shade(shade_out.data);
		shade_out.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	// Writes one register while the block is idle; the block reruns its setup.
	task automatic write_reg(input aatsps_pkg::reg_index_t idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			aatsps_pkg::REG_START_X: seg_ax = int'($signed(v[13:0]));
			aatsps_pkg::REG_START_Y: seg_ay = int'($signed(v[13:0]));
			aatsps_pkg::REG_END_X: seg_bx = int'($signed(v[13:0]));
			aatsps_pkg::REG_END_Y: seg_by = int'($signed(v[13:0]));
			aatsps_pkg::REG_THICKNESS: pen_width = v[9:0];
			aatsps_pkg::REG_PEN_COLOUR: stroke_colour = v;
			aatsps_pkg::REG_CANVAS_WIDTH: canvas_w = v[9:0];
			aatsps_pkg::REG_CANVAS_HEIGHT: canvas_h = v[9:0];
			default: ;
		endcase
	endtask

	task automatic set_segment(input int ax, ay, bx, by, w, input logic [15:0] c,
			input int cw, ch);
		write_reg(aatsps_pkg::REG_START_X, 16'(ax));
		write_reg(aatsps_pkg::REG_START_Y, 16'(ay));
		write_reg(aatsps_pkg::REG_END_X, 16'(bx));
		write_reg(aatsps_pkg::REG_END_Y, 16'(by));
		write_reg(aatsps_pkg::REG_THICKNESS, 16'(w));
		write_reg(aatsps_pkg::REG_PEN_COLOUR, c);
		write_reg(aatsps_pkg::REG_CANVAS_WIDTH, 16'(cw));
		write_reg(aatsps_pkg::REG_CANVAS_HEIGHT, 16'(ch));
	endtask

	// Offers one pixel word, with a random gap first, and holds it until accepted.
	// Valid stays high from one word to the next when no gap is drawn.
	task automatic send_pixel(input aatsps_pkg::pixel_word_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.data <= p;
		board.note_pixel(shade_pixel(p));
		do @(posedge clk); while (!pix_in.ready);
	endtask

	// Drops valid and waits until every expected word has come back.
	task automatic drain();
		pix_in.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Pixels are drawn mostly near the segment so that partial coverage is common.
	function automatic aatsps_pkg::pixel_word_t near_pixel();
		aatsps_pkg::pixel_word_t p;
		int t, cx, cy;
		p.old_colour = 16'($urandom);
		if ($urandom_range(9) < 2) begin
			p.pixel_x = 9'($urandom);
			p.pixel_y = 9'($urandom);
		end else begin
			t = int'($urandom_range(100));
			cx = (seg_ax + (seg_bx - seg_ax) * t / 100) / 16 + int'($urandom_range(8)) - 4;
			cy = (seg_ay + (seg_by - seg_ay) * t / 100) / 16 + int'($urandom_range(8)) - 4;
			p.pixel_x = 9'(cx < 0 ? 0 : (cx > 511 ? 511 : cx));
			p.pixel_y = 9'(cy < 0 ? 0 : (cy > 511 ? 511 : cy));
		end
		return p;
	endfunction

	task automatic random_segment();
		int w;
		w = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(96);
		set_segment($urandom_range(8800) - 300, $urandom_range(8800) - 300,
			$urandom_range(8800) - 300, $urandom_range(8800) - 300, w,
			16'($urandom), $urandom_range(512, 1), $urandom_range(512, 1));
	endtask

	initial begin
		aatsps_pkg::pixel_word_t p;
		seg_ax = 0; seg_ay = 0; seg_bx = 0; seg_by = 0;
		pen_width = 0; stroke_colour = '0; canvas_w = 512; canvas_h = 512;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset settings the radius is zero, so nothing is drawn.
		p = '{9'd0, 9'd0, 16'hffff};
		send_pixel(p);
		drain();

		// A diagonal body, full-scale coordinates and a thick pen.
		set_segment(-8192, -8192, 8191, 8191, 40, 16'hffff, 512, 512);
		for (int i = 0; i < 6; i++) begin
			p = '{9'(i * 100), 9'(i * 100 + (i % 3) - 1), 16'(i * 16'h2a55)};
			send_pixel(p);
		end
		send_pixel('{9'd511, 9'd511, 16'h0000});
		send_pixel('{9'd511, 9'd0, 16'hffff});
		drain();
		// Zero-length segment: round dot, with a canvas that clips its right half.
		set_segment(1000, 1000, 1000, 1000, 1023, 16'hf800, 64, 512);
		for (int i = 0; i < 8; i++)
			send_pixel('{9'(58 + i * 2), 9'(60 + i), 16'h07e0});
		drain();
		// Thickness one gives radius zero, so nothing is drawn; then a wider pen meets both caps.
		set_segment(160, 160, 800, 160, 1, 16'h001f, 1, 1);
		send_pixel('{9'd20, 9'd10, 16'h1234});
		drain();
		write_reg(aatsps_pkg::REG_THICKNESS, 16'd24);
		repeat (2) @(posedge clk);
		send_pixel('{9'd9, 9'd10, 16'h1234});
		send_pixel('{9'd50, 9'd10, 16'h1234});
		send_pixel('{9'd0, 9'd0, 16'h1234});
		send_pixel('{9'd20, 9'd11, 16'h1234});
		drain();

		// Random part in three pacing phases; the second starts with a forced stall.
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 66;
				recv_idle_pct = 8;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int k = 0; k < 4; k++) begin
				random_segment();
				if (phase == 1 && k == 0) begin
					fork
						begin
							hold_off = 1'b1;
							repeat (300) @(posedge clk);
							hold_off = 1'b0;
						end
					join_none
				end
				for (int n = 0; n < 42; n++) send_pixel(near_pixel());
				drain();
			end
		end

		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
